/* rtl/ffrst_pkg.sv */
// Shared constants, types and helpers of the first-fit resizing slot table.
package ffrst_pkg;

  localparam int MaxSlots = 256;
  localparam int IdxW     = $clog2(MaxSlots);
  localparam int SzW      = IdxW + 1;
  localparam int MinW     = 5;
  localparam int ModeW    = 2;
  localparam int IdW      = 16;
  localparam int SlotIdxW = 8;
  localparam int StatusW  = 2;
  localparam int UsedW    = 8;
  localparam int SizeOutW = 9;
  localparam int InDataW  = 32;
  localparam int OutDataW = 48;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,
    S_REM_ADDR,
    S_REM_CMP,
    S_REM_CHECK,
    S_PACK_ADDR,
    S_PACK_MOVE,
    S_READ_ADDR,
    S_READ_DATA,
    S_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    inc;
    logic    set_status;
    status_e status;
    logic    ins_write;
    logic    rd_slot;
    logic    rd_index;
    logic    rem_free;
    logic    pack_start;
    logic    pack_move;
    logic    halve;
    logic    read_capture;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end;
    logic slot_free;
    logic id_match;
    logic idx_in_range;
    logic pack_needed;
    logic out_free;
  } stat_t;

  // Effective minimum size: at least two, at most the capacity.
  function automatic logic [SzW-1:0] eff_min(input logic [MinW-1:0] m);
    int v;
    v = int'(m);
    if (v < 2) v = 2;
    if (v > MaxSlots) v = MaxSlots;
    return SzW'(v);
  endfunction

endpackage

/* rtl/ffrst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffrst_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ffrst_ctrl.sv */
// Sequencing state machine of the slot table: scans, packing and result hand-off.
module ffrst_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [ffrst_pkg::ModeW-1:0] mode_i,
  input  ffrst_pkg::stat_t            stat_i,
  output ffrst_pkg::cmd_t             cmd_o
);

  ffrst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffrst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffrst_pkg::S_IDLE: begin
        if (s_valid_i) begin
          unique case (ffrst_pkg::mode_e'(mode_i))
            ffrst_pkg::MODE_INSERT: state_d = ffrst_pkg::S_INS_SCAN;
            ffrst_pkg::MODE_REMOVE: state_d = ffrst_pkg::S_REM_ADDR;
            ffrst_pkg::MODE_READ:   state_d = ffrst_pkg::S_READ_ADDR;
            default:                state_d = ffrst_pkg::S_DONE;
          endcase
        end
      end
      ffrst_pkg::S_INS_SCAN: begin
        if (stat_i.scan_end || stat_i.slot_free) state_d = ffrst_pkg::S_DONE;
      end
      ffrst_pkg::S_REM_ADDR: begin
        state_d = stat_i.scan_end ? ffrst_pkg::S_DONE : ffrst_pkg::S_REM_CMP;
      end
      ffrst_pkg::S_REM_CMP: begin
        state_d = stat_i.id_match ? ffrst_pkg::S_REM_CHECK : ffrst_pkg::S_REM_ADDR;
      end
      ffrst_pkg::S_REM_CHECK: begin
        state_d = stat_i.pack_needed ? ffrst_pkg::S_PACK_ADDR : ffrst_pkg::S_DONE;
      end
      ffrst_pkg::S_PACK_ADDR: begin
        priority if (stat_i.scan_end) begin
          state_d = ffrst_pkg::S_DONE;
        end else if (!stat_i.slot_free) begin
          state_d = ffrst_pkg::S_PACK_MOVE;
        end
      end
      ffrst_pkg::S_PACK_MOVE: state_d = ffrst_pkg::S_PACK_ADDR;
      ffrst_pkg::S_READ_ADDR: begin
        state_d = stat_i.idx_in_range ? ffrst_pkg::S_READ_DATA : ffrst_pkg::S_DONE;
      end
      ffrst_pkg::S_READ_DATA: state_d = ffrst_pkg::S_DONE;
      ffrst_pkg::S_DONE: begin
        if (stat_i.out_free) state_d = ffrst_pkg::S_IDLE;
      end
      default: state_d = ffrst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.status = ffrst_pkg::ST_OK;
    s_ready_o    = 1'b0;
    unique case (state_q)
      ffrst_pkg::S_IDLE: begin
        s_ready_o  = 1'b1;
        cmd_o.load = s_valid_i;
      end
      ffrst_pkg::S_INS_SCAN: begin
        priority if (stat_i.scan_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ffrst_pkg::ST_FULL;
        end else if (stat_i.slot_free) begin
          cmd_o.ins_write = 1'b1;
        end else begin
          cmd_o.inc = 1'b1;
        end
      end
      ffrst_pkg::S_REM_ADDR: begin
        if (stat_i.scan_end) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ffrst_pkg::ST_NOT_FOUND;
        end else begin
          cmd_o.rd_slot = 1'b1;
        end
      end
      ffrst_pkg::S_REM_CMP: begin
        if (stat_i.id_match) begin
          cmd_o.rem_free = 1'b1;
        end else begin
          cmd_o.inc = 1'b1;
        end
      end
      ffrst_pkg::S_REM_CHECK: begin
        cmd_o.pack_start = stat_i.pack_needed;
      end
      ffrst_pkg::S_PACK_ADDR: begin
        // skip empty slots without a read
        priority if (stat_i.scan_end) begin
          cmd_o.halve = 1'b1;
        end else if (stat_i.slot_free) begin
          cmd_o.inc = 1'b1;
        end else begin
          cmd_o.rd_slot = 1'b1;
        end
      end
      ffrst_pkg::S_PACK_MOVE: cmd_o.pack_move = 1'b1;
      ffrst_pkg::S_READ_ADDR: begin
        if (stat_i.idx_in_range) begin
          cmd_o.rd_index = 1'b1;
        end else begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ffrst_pkg::ST_RANGE;
        end
      end
      ffrst_pkg::S_READ_DATA: cmd_o.read_capture = 1'b1;
      ffrst_pkg::S_DONE: cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/ffrst_dp.sv */
// Datapath of the slot table: slot RAM, valid bits, size and count, result register.
module ffrst_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffrst_pkg::MinW-1:0]     cfg_wdata_i,
  input  logic [ffrst_pkg::ModeW-1:0]    mode_i,
  input  logic [ffrst_pkg::IdW-1:0]      car_id_i,
  input  logic [ffrst_pkg::SlotIdxW-1:0] slot_index_i,
  input  ffrst_pkg::cmd_t                cmd_i,
  output ffrst_pkg::stat_t               stat_o,
  input  logic                           m_ready_i,
  output logic                           m_valid_o,
  output logic [ffrst_pkg::StatusW-1:0]  status_o,
  output logic [ffrst_pkg::UsedW-1:0]    slot_used_o,
  output logic [ffrst_pkg::IdW-1:0]      id_out_o,
  output logic                           occupied_o,
  output logic [ffrst_pkg::SizeOutW-1:0] active_size_o,
  output logic [ffrst_pkg::SizeOutW-1:0] live_count_o
);

  localparam int SzW  = ffrst_pkg::SzW;
  localparam int IdxW = ffrst_pkg::IdxW;

  logic [ffrst_pkg::MinW-1:0]     min_q;
  logic [SzW-1:0]                 size_q, count_q;
  logic [ffrst_pkg::MaxSlots-1:0] valid_q;
  logic [SzW-1:0]                 i_q, w_q;
  logic [ffrst_pkg::IdW-1:0]      id_q;
  logic [ffrst_pkg::SlotIdxW-1:0] idx_q;

  ffrst_pkg::status_e             res_status_q;
  logic [ffrst_pkg::UsedW-1:0]    res_used_q;
  logic [ffrst_pkg::IdW-1:0]      res_id_q;
  logic                           res_occ_q;

  logic                           m_valid_q;
  ffrst_pkg::status_e             out_status_q;
  logic [ffrst_pkg::UsedW-1:0]    out_used_q;
  logic [ffrst_pkg::IdW-1:0]      out_id_q;
  logic                           out_occ_q;
  logic [ffrst_pkg::SizeOutW-1:0] out_size_q, out_count_q;

  logic [IdxW-1:0]           slot_i, slot_w, slot_idx;
  logic [SzW-1:0]            min_eff, count_inc, grow_size, empty;
  logic [SzW:0]              size_dbl;
  logic [SzW+1:0]            empty_x3, size_x2;
  logic                      ram_we, ram_re;
  logic [IdxW-1:0]           ram_waddr, ram_raddr;
  logic [ffrst_pkg::IdW-1:0] ram_wdata, ram_rdata;

  assign slot_i   = i_q[IdxW-1:0];
  assign slot_w   = w_q[IdxW-1:0];
  assign slot_idx = IdxW'(idx_q);
  assign min_eff  = ffrst_pkg::eff_min(min_q);

  assign count_inc = count_q + SzW'(1);
  assign size_dbl  = {size_q, 1'b0};
  assign grow_size = (size_dbl > (SzW+1)'(ffrst_pkg::MaxSlots)) ?
                     SzW'(ffrst_pkg::MaxSlots) : size_dbl[SzW-1:0];

  // pack when 3*empty >= 2*size
  assign empty    = size_q - count_q;
  assign empty_x3 = (SzW+2)'({empty, 1'b0}) + (SzW+2)'(empty);
  assign size_x2  = (SzW+2)'({size_q, 1'b0});

  assign stat_o.scan_end     = (i_q >= size_q);
  assign stat_o.slot_free    = !valid_q[slot_i];
  assign stat_o.id_match     = valid_q[slot_i] && (ram_rdata == id_q);
  assign stat_o.idx_in_range = (32'(idx_q) < 32'(size_q));
  assign stat_o.pack_needed  = (empty_x3 >= size_x2);
  assign stat_o.out_free     = !m_valid_q || m_ready_i;

  assign ram_we    = cmd_i.ins_write || cmd_i.pack_move;
  assign ram_waddr = cmd_i.pack_move ? slot_w : slot_i;
  assign ram_wdata = cmd_i.pack_move ? ram_rdata : id_q;
  assign ram_re    = cmd_i.rd_slot || cmd_i.rd_index;
  assign ram_raddr = cmd_i.rd_index ? slot_idx : slot_i;

  ffrst_ram #(
    .Width (ffrst_pkg::IdW),
    .Depth (ffrst_pkg::MaxSlots)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Table state: min size, active size, live count, valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= ffrst_pkg::MinW'(2);
      size_q  <= ffrst_pkg::eff_min(ffrst_pkg::MinW'(2));
      count_q <= '0;
      valid_q <= '0;
    end else if (cfg_we_i) begin
      min_q   <= cfg_wdata_i;
      size_q  <= ffrst_pkg::eff_min(cfg_wdata_i);
      count_q <= '0;
      valid_q <= '0;
    end else begin
      if (cmd_i.ins_write) begin
        valid_q[slot_i] <= 1'b1;
        count_q         <= count_inc;
        if (count_inc >= size_q) size_q <= grow_size;
      end
      if (cmd_i.rem_free) begin
        valid_q[slot_i] <= 1'b0;
        count_q         <= count_q - SzW'(1);
      end
      if (cmd_i.pack_move) begin
        // clear source first so a move onto itself stays valid
        valid_q[slot_i] <= 1'b0;
        valid_q[slot_w] <= 1'b1;
      end
      if (cmd_i.halve && ({1'b0, size_q[SzW-1:1]} >= min_eff)) begin
        size_q <= {1'b0, size_q[SzW-1:1]};
      end
    end
  end

  // Scan pointers and latched item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      w_q <= '0;
    end else begin
      if (cmd_i.load || cmd_i.pack_start) begin
        i_q <= '0;
        w_q <= '0;
      end else if (cmd_i.inc || cmd_i.pack_move) begin
        i_q <= i_q + SzW'(1);
      end
      if (cmd_i.pack_move) w_q <= w_q + SzW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_q  <= car_id_i;
      idx_q <= slot_index_i;
    end
  end

  // Result under construction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_status_q <= ffrst_pkg::ST_OK;
      res_used_q   <= '0;
      res_id_q     <= '0;
      res_occ_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        res_status_q <= ffrst_pkg::ST_OK;
        res_used_q   <= (ffrst_pkg::mode_e'(mode_i) == ffrst_pkg::MODE_READ) ?
                        ffrst_pkg::UsedW'(slot_index_i) : '0;
        res_id_q     <= '0;
        res_occ_q    <= 1'b0;
      end
      if (cmd_i.set_status) res_status_q <= cmd_i.status;
      if (cmd_i.ins_write || cmd_i.rem_free) res_used_q <= ffrst_pkg::UsedW'(i_q);
      if (cmd_i.read_capture) begin
        res_occ_q <= valid_q[slot_idx];
        res_id_q  <= valid_q[slot_idx] ? ram_rdata : '0;
      end
    end
  end

  // Output register: holds a finished beat while the next item runs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_used_q   <= res_used_q;
      out_id_q     <= res_id_q;
      out_occ_q    <= res_occ_q;
      out_size_q   <= ffrst_pkg::SizeOutW'(size_q);
      out_count_q  <= ffrst_pkg::SizeOutW'(count_q);
    end
  end

  assign m_valid_o     = m_valid_q;
  assign status_o      = out_status_q;
  assign slot_used_o   = out_used_q;
  assign id_out_o      = out_id_q;
  assign occupied_o    = out_occ_q;
  assign active_size_o = out_size_q;
  assign live_count_o  = out_count_q;

`ifndef SYNTHESIS
  a_count_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= size_q)
    else $error("live count exceeds active size");

  a_size_ge_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_q >= min_eff)
    else $error("active size below minimum");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("live count disagrees with valid bits");

  a_pack_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pack_move |-> (w_q <= i_q))
    else $error("pack write pointer passed read pointer");
`endif

endmodule

/* rtl/first_fit_resizing_slot_table.sv */
// Top level of the first-fit resizing slot table.
// One item is taken at a time. An insert checks one valid bit per cycle
// until it finds a free slot or reaches the active size; a read fetches the
// indexed slot unless the index is past the active size; and a remove
// searches the slot RAM with a read and a compare per slot. When the table
// packs after a remove, which it does only when live is at most size/3, a
// pack pass follows the search. The next beat is accepted in the cycle after
// the result is loaded, and the load stalls while the output register still
// holds a beat the receiver has not taken. A finished beat waits in the output
// register while the next item is accepted. Writing min_slots empties the table
// in the same cycle; reset needs no clearing pass.
module first_fit_resizing_slot_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ffrst_pkg::MinW-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [1:0] mode, [17:2] car_id, [25:18] slot_index, [31:26] zero
  input  logic [ffrst_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [9:2] slot_used, [25:10] id_out, [26] occupied,
  // [35:27] active_size, [44:36] live_count, [47:45] zero
  output logic [ffrst_pkg::OutDataW-1:0]      m_axis_tdata
);

  ffrst_pkg::cmd_t  cmd;
  ffrst_pkg::stat_t stat;

  logic [ffrst_pkg::ModeW-1:0]    mode;
  logic [ffrst_pkg::IdW-1:0]      car_id;
  logic [ffrst_pkg::SlotIdxW-1:0] slot_index;

  logic [ffrst_pkg::StatusW-1:0]  status;
  logic [ffrst_pkg::UsedW-1:0]    slot_used;
  logic [ffrst_pkg::IdW-1:0]      id_out;
  logic                           occupied;
  logic [ffrst_pkg::SizeOutW-1:0] active_size, live_count;

  assign mode       = s_axis_tdata[1:0];
  assign car_id     = s_axis_tdata[17:2];
  assign slot_index = s_axis_tdata[25:18];

  ffrst_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .mode_i    (mode),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ffrst_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .mode_i        (mode),
    .car_id_i      (car_id),
    .slot_index_i  (slot_index),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_ready_i     (m_axis_tready),
    .m_valid_o     (m_axis_tvalid),
    .status_o      (status),
    .slot_used_o   (slot_used),
    .id_out_o      (id_out),
    .occupied_o    (occupied),
    .active_size_o (active_size),
    .live_count_o  (live_count)
  );

  assign m_axis_tdata = {3'b000, live_count, active_size, occupied, id_out, slot_used, status};

endmodule
